// File: rtl/mox_fuel_conductivity_eval_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the MOX fuel conductivity core
// Checks are clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MOX_FUEL_CONDUCTIVITY_EVAL_CORE_ASSERT_SVH
`define MOX_FUEL_CONDUCTIVITY_EVAL_CORE_ASSERT_SVH

// Plain property check.
`define MFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication.
`define MFC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	`MFC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: rtl/mfc_pkg.sv
// ---------------------------------------------------------------------------
// mfc_pkg
// Widths, constants, register codes and shared types of the conductivity core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfc_pkg;

	localparam int TAG_W    = 24;
	localparam int TEMP_W   = 16;
	localparam int BU_W     = 18;
	localparam int COND_W   = 24;
	localparam int DEN_W    = 49;
	localparam int TERM_W   = 41;
	localparam int YE_W     = 37;
	localparam int TSQ_W    = 32;
	localparam int YB_W     = 41;
	localparam int NE_W     = 21;
	localparam int NB_W     = 11;
	localparam int FRAC_W   = 16;
	localparam int ACC_W    = 31;
	localparam int TAB_W    = 30;
	localparam int EB_W     = 23;
	localparam int SUM_W    = 42;
	localparam int K0_W     = 43;
	localparam int PROD_W   = 55;
	localparam int NUM_W    = 64;
	localparam int NUM_HI_W = NUM_W - TERM_W;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [TERM_W-1:0] TERM_CAP = 41'd1099511627776;
	localparam logic [ACC_W-1:0] ACC_ONE = 31'd1073741824;
	localparam logic [DEN_W-1:0] DIV1_REM = 49'd524288;
	localparam logic [COND_W-1:0] OUT_MAX = 24'hFFFFFF;
	localparam logic [NE_W-1:0] E_SHIFT_BIAS = 21'd10;
	localparam logic [NE_W-1:0] E_SHIFT_LIMIT = 21'd74;
	localparam logic [NB_W:0] B_SHIFT_BIAS = 12'd8;
	localparam logic [NB_W:0] B_SHIFT_LIMIT = 12'd64;

	localparam int FRONT_LAT = 3;
	localparam int MID_LAT   = 2;
	localparam int BACK_LAT  = 6;
	localparam int LATENCY   = FRONT_LAT + TERM_W + YE_W + FRAC_W + MID_LAT + TERM_W + BACK_LAT;

	localparam logic [CFG_IDX_W-1:0] CFG_DENOM_OFFSET   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DENOM_SLOPE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHONON_COEF    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATION     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_COND     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_BURNUP     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_POROSITY       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_PERTURB        = 3'd7;

	localparam logic [31:0] RST_DENOM_OFFSET = 32'd82721070;
	localparam logic [31:0] RST_DENOM_SLOPE  = 32'd262783273;
	localparam logic [23:0] RST_PHONON_COEF  = 24'd80414;
	localparam logic [19:0] RST_ACTIVATION   = 20'd273752;
	localparam logic [23:0] RST_LIMIT_COND   = 24'd115016;
	localparam logic [31:0] RST_INV_BURNUP   = 32'd8539897;
	localparam logic [16:0] RST_POROSITY     = 17'd65536;
	localparam logic [19:0] RST_PERTURB      = 20'd65536;

	typedef struct packed {
		logic [31:0] denom_offset;
		logic [31:0] denom_slope;
		logic [23:0] phonon_coef;
		logic [19:0] activation_temp;
		logic [23:0] limit_conductivity;
		logic [31:0] inv_burnup_scale;
		logic [16:0] porosity_factor;
		logic [19:0] perturb_gain;
	} cfg_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [TEMP_W-1:0] t;
		logic [YE_W-1:0]   ye;
		logic [TSQ_W-1:0]  tsq;
		logic [YB_W-1:0]   yb;
		logic              ovf;
	} front_side_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [TERM_W-1:0] term1;
		logic [TSQ_W-1:0]  tsq;
		logic [YB_W-1:0]   yb;
	} d2_side_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [TERM_W-1:0] term1;
		logic [TSQ_W-1:0]  tsq;
		logic [NE_W-1:0]   ne;
		logic [NB_W-1:0]   nb;
	} pw_side_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [TERM_W-1:0] term1;
		logic [EB_W-1:0]   eb;
		logic              ovf;
	} d3_side_t;

	// Factors 2^(-2^-j), j = 1..16, in Q0.30.
	function automatic logic [TAB_W-1:0] pow2_tab(input logic [3:0] idx);
		logic [TAB_W-1:0] r;
		case (idx)
			4'd0:    r = 30'd759250125;
			4'd1:    r = 30'd902905651;
			4'd2:    r = 30'd984625594;
			4'd3:    r = 30'd1028218693;
			4'd4:    r = 30'd1050733751;
			4'd5:    r = 30'd1062175491;
			4'd6:    r = 30'd1067942999;
			4'd7:    r = 30'd1070838486;
			4'd8:    r = 30'd1072289173;
			4'd9:    r = 30'd1073015252;
			4'd10:   r = 30'd1073378477;
			4'd11:   r = 30'd1073560135;
			4'd12:   r = 30'd1073650976;
			4'd13:   r = 30'd1073696399;
			4'd14:   r = 30'd1073719111;
			default: r = 30'd1073730468;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/mfc_div.sv
// ---------------------------------------------------------------------------
// mfc_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfc_div #(
	parameter int DW = 16,
	parameter int QW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [DW-1:0] in_rem,
	input  logic [DW-1:0] in_div,
	input  logic [QW-1:0] in_num,
	input  logic [SW-1:0] in_side,
	output logic          out_v,
	output logic [QW-1:0] out_quo,
	output logic [SW-1:0] out_side
);

	logic          v_s    [QW];
	logic [DW-1:0] rem_s  [QW];
	logic [DW-1:0] div_s  [QW];
	logic [QW-1:0] nq_s   [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic          v_p;
		logic [DW-1:0] rem_p;
		logic [DW-1:0] div_p;
		logic [QW-1:0] nq_p;
		logic [SW-1:0] side_p;
		logic [DW:0]   r2;
		logic [DW:0]   diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign v_p    = in_v;
			assign rem_p  = in_rem;
			assign div_p  = in_div;
			assign nq_p   = in_num;
			assign side_p = in_side;
		end else begin : g_next
			assign v_p    = v_s[i-1];
			assign rem_p  = rem_s[i-1];
			assign div_p  = div_s[i-1];
			assign nq_p   = nq_s[i-1];
			assign side_p = side_s[i-1];
		end

		// Bring down the next numerator bit and try the subtraction.
		assign r2   = {rem_p, nq_p[QW-1]};
		assign diff = r2 - {1'b0, div_p};
		assign ge   = (r2 >= {1'b0, div_p});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
				div_s[i]  <= div_p;
				nq_s[i]   <= {nq_p[QW-2:0], ge};
				side_s[i] <= side_p;
			end
		end
	end

	assign out_v    = v_s[QW-1];
	assign out_quo  = nq_s[QW-1];
	assign out_side = side_s[QW-1];

endmodule

`default_nettype wire

// File: rtl/mfc_pow2.sv
// ---------------------------------------------------------------------------
// mfc_pow2
// Two-lane 2^-f evaluator, one table factor per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mox_fuel_conductivity_eval_core_assert.svh"

module mfc_pow2 #(
	parameter int SW = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_v,
	input  logic [mfc_pkg::FRAC_W-1:0] in_fa,
	input  logic [mfc_pkg::FRAC_W-1:0] in_fb,
	input  logic [SW-1:0]            in_side,
	output logic                     out_v,
	output logic [mfc_pkg::ACC_W-1:0] out_pa,
	output logic [mfc_pkg::ACC_W-1:0] out_pb,
	output logic [SW-1:0]            out_side
);

	localparam int FW = mfc_pkg::FRAC_W;
	localparam int AW = mfc_pkg::ACC_W;
	localparam int MW = AW + mfc_pkg::TAB_W;

	logic          v_s    [FW];
	logic [AW-1:0] acca_s [FW];
	logic [AW-1:0] accb_s [FW];
	logic [FW-1:0] fa_s   [FW];
	logic [FW-1:0] fb_s   [FW];
	logic [SW-1:0] side_s [FW];

	for (genvar j = 0; j < FW; j++) begin : g_stage
		logic          v_p;
		logic [AW-1:0] acca_p;
		logic [AW-1:0] accb_p;
		logic [FW-1:0] fa_p;
		logic [FW-1:0] fb_p;
		logic [SW-1:0] side_p;
		logic [MW-1:0] ma;
		logic [MW-1:0] mb;
		logic [mfc_pkg::TAB_W-1:0] fac;

		if (j == 0) begin : g_first
			assign v_p    = in_v;
			assign acca_p = mfc_pkg::ACC_ONE;
			assign accb_p = mfc_pkg::ACC_ONE;
			assign fa_p   = in_fa;
			assign fb_p   = in_fb;
			assign side_p = in_side;
		end else begin : g_next
			assign v_p    = v_s[j-1];
			assign acca_p = acca_s[j-1];
			assign accb_p = accb_s[j-1];
			assign fa_p   = fa_s[j-1];
			assign fb_p   = fb_s[j-1];
			assign side_p = side_s[j-1];
		end

		// Multiply by the factor and round half up back to Q1.30.
		assign fac = mfc_pkg::pow2_tab(4'(j));
		assign ma  = MW'(acca_p) * MW'(fac) + (MW'(1) << (mfc_pkg::TAB_W - 1));
		assign mb  = MW'(accb_p) * MW'(fac) + (MW'(1) << (mfc_pkg::TAB_W - 1));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acca_s[j] <= fa_p[FW-1-j] ? ma[MW-1:mfc_pkg::TAB_W] : acca_p;
				accb_s[j] <= fb_p[FW-1-j] ? mb[MW-1:mfc_pkg::TAB_W] : accb_p;
				fa_s[j]   <= fa_p;
				fb_s[j]   <= fb_p;
				side_s[j] <= side_p;
			end
		end
	end

	assign out_v    = v_s[FW-1];
	assign out_pa   = acca_s[FW-1];
	assign out_pb   = accb_s[FW-1];
	assign out_side = side_s[FW-1];

	`MFC_ASSERT_IMPLY(a_pow2_bound, out_v, (out_pa <= mfc_pkg::ACC_ONE) && (out_pb <= mfc_pkg::ACC_ONE), "pow2 result above one")

endmodule

`default_nettype wire

// File: rtl/mfc_front.sv
// ---------------------------------------------------------------------------
// mfc_front
// Input register and the products that feed the dividers and exponentials.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  mfc_pkg::cfg_t               cfg,
	input  logic                        in_v,
	input  logic [mfc_pkg::TAG_W-1:0]   in_tag,
	input  logic [mfc_pkg::TEMP_W-1:0]  in_temp,
	input  logic [mfc_pkg::BU_W-1:0]    in_bu,
	output logic                        out_v,
	output logic [mfc_pkg::DEN_W-1:0]   out_den,
	output mfc_pkg::front_side_t        out_side
);

	logic                       v_s1, v_s2, v_s3;
	logic [mfc_pkg::TAG_W-1:0]  tag_s1, tag_s2, tag_s3;
	logic [mfc_pkg::TEMP_W-1:0] t_s1, t_s2, t_s3;
	logic [mfc_pkg::BU_W-1:0]   bu_s1;
	logic [mfc_pkg::DEN_W-1:0]  den_s2, den_s3;
	logic [mfc_pkg::YE_W-1:0]   ye_s2, ye_s3;
	logic [mfc_pkg::TSQ_W-1:0]  tsq_s2, tsq_s3;
	logic [29:0]                z_s2;
	logic [mfc_pkg::YB_W-1:0]   yb_s3;
	logic                       ovf_s3;

	logic [47:0] bt;
	logic [50:0] ep;
	logic [49:0] zp;
	logic [60:0] ybp;

	assign bt  = 48'(cfg.denom_slope) * 48'(t_s1);
	assign ep  = 51'(cfg.activation_temp) * 51'(mfc_pkg::LOG2E_Q30);
	assign zp  = 50'(bu_s1) * 50'(cfg.inv_burnup_scale);
	assign ybp = 61'(z_s2) * 61'(mfc_pkg::LOG2E_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// A temperature of zero is taken as one.
			tag_s1 <= in_tag;
			t_s1   <= (in_temp == '0) ? mfc_pkg::TEMP_W'(1) : in_temp;
			bu_s1  <= in_bu;

			tag_s2 <= tag_s1;
			t_s2   <= t_s1;
			den_s2 <= mfc_pkg::DEN_W'({cfg.denom_offset, 12'd0}) + mfc_pkg::DEN_W'(bt);
			ye_s2  <= ep[50:14];
			tsq_s2 <= 32'(t_s1) * 32'(t_s1);
			z_s2   <= zp[49:20];

			tag_s3 <= tag_s2;
			t_s3   <= t_s2;
			den_s3 <= den_s2;
			ye_s3  <= ye_s2;
			tsq_s3 <= tsq_s2;
			yb_s3  <= ybp[60:20];
			ovf_s3 <= (den_s2 <= mfc_pkg::DIV1_REM);
		end
	end

	assign out_v        = v_s3;
	assign out_den      = den_s3;
	assign out_side.tag = tag_s3;
	assign out_side.t   = t_s3;
	assign out_side.ye  = ye_s3;
	assign out_side.tsq = tsq_s3;
	assign out_side.yb  = yb_s3;
	assign out_side.ovf = ovf_s3;

endmodule

`default_nettype wire

// File: rtl/mfc_mid.sv
// ---------------------------------------------------------------------------
// mfc_mid
// Phonon term numerator and burnup decay factor, two stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfc_mid (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  mfc_pkg::cfg_t                 cfg,
	input  logic                          in_v,
	input  logic [mfc_pkg::ACC_W-1:0]     in_pa,
	input  logic [mfc_pkg::ACC_W-1:0]     in_pb,
	input  mfc_pkg::pw_side_t             in_side,
	output logic                          out_v,
	output logic [mfc_pkg::TSQ_W-1:0]     out_rem,
	output logic [mfc_pkg::TERM_W-1:0]    out_num,
	output logic [mfc_pkg::TSQ_W-1:0]     out_div,
	output mfc_pkg::d3_side_t             out_side
);

	logic                        v_s1, v_s2;
	logic [mfc_pkg::PROD_W-1:0]  prod_s1;
	logic [mfc_pkg::EB_W-1:0]    eb_s1, eb_s2;
	logic [mfc_pkg::NE_W-1:0]    ne_s1;
	logic [mfc_pkg::TAG_W-1:0]   tag_s1, tag_s2;
	logic [mfc_pkg::TERM_W-1:0]  term1_s1, term1_s2;
	logic [mfc_pkg::TSQ_W-1:0]   tsq_s1, tsq_s2;
	logic [mfc_pkg::NUM_W-1:0]   num_s2;
	logic                        ovf_s2;

	logic [mfc_pkg::NB_W:0]      bsh;
	logic [mfc_pkg::EB_W-1:0]    eb;
	logic [mfc_pkg::NUM_W-1:0]   p64;
	logic [mfc_pkg::NUM_W-1:0]   num;

	assign bsh = (mfc_pkg::NB_W + 1)'(in_side.nb) + mfc_pkg::B_SHIFT_BIAS;

	always_comb begin
		if (bsh >= mfc_pkg::B_SHIFT_LIMIT) begin
			eb = '0;
		end else begin
			eb = mfc_pkg::EB_W'(in_pb >> bsh);
		end
	end

	// The left shift wraps at 64 bits like the numerator it models.
	assign p64 = mfc_pkg::NUM_W'(prod_s1);

	always_comb begin
		if (ne_s1 <= mfc_pkg::E_SHIFT_BIAS) begin
			num = p64 << (mfc_pkg::E_SHIFT_BIAS - ne_s1);
		end else if (ne_s1 >= mfc_pkg::E_SHIFT_LIMIT) begin
			num = '0;
		end else begin
			num = p64 >> (ne_s1 - mfc_pkg::E_SHIFT_BIAS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= mfc_pkg::PROD_W'(cfg.phonon_coef) * mfc_pkg::PROD_W'(in_pa);
			eb_s1    <= eb;
			ne_s1    <= in_side.ne;
			tag_s1   <= in_side.tag;
			term1_s1 <= in_side.term1;
			tsq_s1   <= in_side.tsq;

			num_s2   <= num;
			ovf_s2   <= (mfc_pkg::TSQ_W'(num[mfc_pkg::NUM_W-1:mfc_pkg::TERM_W]) >= tsq_s1);
			eb_s2    <= eb_s1;
			tag_s2   <= tag_s1;
			term1_s2 <= term1_s1;
			tsq_s2   <= tsq_s1;
		end
	end

	assign out_v          = v_s2;
	assign out_rem        = mfc_pkg::TSQ_W'(num_s2[mfc_pkg::NUM_W-1:mfc_pkg::TERM_W]);
	assign out_num        = num_s2[mfc_pkg::TERM_W-1:0];
	assign out_div        = tsq_s2;
	assign out_side.tag   = tag_s2;
	assign out_side.term1 = term1_s2;
	assign out_side.eb    = eb_s2;
	assign out_side.ovf   = ovf_s2;

endmodule

`default_nettype wire

// File: rtl/mfc_back.sv
// ---------------------------------------------------------------------------
// mfc_back
// Porosity scaling, burnup blend, gain and saturation, ending in the
// output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  mfc_pkg::cfg_t                cfg,
	input  logic                         in_v,
	input  logic [mfc_pkg::TERM_W-1:0]   in_q,
	input  mfc_pkg::d3_side_t            in_side,
	output logic                         out_v,
	output logic [mfc_pkg::TAG_W-1:0]    out_tag,
	output logic [mfc_pkg::COND_W-1:0]   out_cond
);

	localparam int KW = mfc_pkg::K0_W;

	logic                        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [mfc_pkg::TAG_W-1:0]   tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	logic [mfc_pkg::EB_W-1:0]    eb_s1, eb_s2, eb_s3;
	logic [mfc_pkg::SUM_W-1:0]   sum_s1;
	logic [KW-1:0]               k0_s2, diff_s3, d_s4, nom_s5;
	logic                        ge_s3, ge_s4;
	logic [mfc_pkg::COND_W-1:0]  cond_s6;

	logic [mfc_pkg::TERM_W-1:0]  term2;
	logic [58:0]                 kp;
	logic [KW-1:0]               kinf;
	logic [65:0]                 dp;
	logic [62:0]                 rp;

	assign term2 = (in_side.ovf || (in_q > mfc_pkg::TERM_CAP)) ? mfc_pkg::TERM_CAP : in_q;
	assign kp    = 59'(sum_s1) * 59'(cfg.porosity_factor);
	assign kinf  = KW'(cfg.limit_conductivity);
	assign dp    = 66'(diff_s3) * 66'(eb_s3);
	assign rp    = 63'(nom_s5) * 63'(cfg.perturb_gain);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1  <= mfc_pkg::SUM_W'(in_side.term1) + mfc_pkg::SUM_W'(term2);
			eb_s1   <= in_side.eb;
			tag_s1  <= in_side.tag;

			k0_s2   <= kp[58:16];
			eb_s2   <= eb_s1;
			tag_s2  <= tag_s1;

			ge_s3   <= (k0_s2 >= kinf);
			diff_s3 <= (k0_s2 >= kinf) ? (k0_s2 - kinf) : (kinf - k0_s2);
			eb_s3   <= eb_s2;
			tag_s3  <= tag_s2;

			d_s4    <= dp[64:22];
			ge_s4   <= ge_s3;
			tag_s4  <= tag_s3;

			// The decayed difference never exceeds the difference itself.
			nom_s5  <= ge_s4 ? (kinf + d_s4) : (kinf - d_s4);
			tag_s5  <= tag_s4;

			cond_s6 <= (rp[62:16] > 47'(mfc_pkg::OUT_MAX)) ? mfc_pkg::OUT_MAX
				: rp[16 +: mfc_pkg::COND_W];
			tag_s6  <= tag_s5;
		end
	end

	assign out_v    = v_s6;
	assign out_tag  = tag_s6;
	assign out_cond = cond_s6;

endmodule

`default_nettype wire

// File: rtl/mox_fuel_conductivity_eval_core.sv
// ---------------------------------------------------------------------------
// mox_fuel_conductivity_eval_core
// MOX fuel thermal conductivity per mesh cell, fully pipelined.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   input    in         in_valid/in_ready    cell_index, temperature, burnup
//   output   out        out_valid/out_ready  cell_tag, conductivity
//   config   in         cfg_we               cfg_index, cfg_data
//
// One beat is accepted per clock cycle unless the output stalls. A beat passes 41, 37
// and 41 stages for the three radix-2 dividers, 16 for the exponential factor chain
// whose two lanes run side by side, and 3 + 2 + 6 for the front, middle and back.
// An output stall freezes every stage at once, so no beat is lost or repeated;
// a new beat is taken whenever the output register is empty or being emptied.
// Reset loads the register defaults and clears every valid bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mox_fuel_conductivity_eval_core_assert.svh"

module mox_fuel_conductivity_eval_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mfc_pkg::TAG_W-1:0]      cell_index,
	input  logic [mfc_pkg::TEMP_W-1:0]     temperature,
	input  logic [mfc_pkg::BU_W-1:0]       burnup,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mfc_pkg::TAG_W-1:0]      cell_tag,
	output logic [mfc_pkg::COND_W-1:0]     conductivity,
	input  logic                           cfg_we,
	input  logic [mfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfc_pkg::CFG_W-1:0]      cfg_data
);

	localparam int OCC_W = $clog2(mfc_pkg::LATENCY + 1);

	// Configuration registers. The user must change them only while the pipeline is
	// empty; the block does not enforce this. Every stage reads them directly.
	mfc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.denom_offset       <= mfc_pkg::RST_DENOM_OFFSET;
			cfg_q.denom_slope        <= mfc_pkg::RST_DENOM_SLOPE;
			cfg_q.phonon_coef        <= mfc_pkg::RST_PHONON_COEF;
			cfg_q.activation_temp    <= mfc_pkg::RST_ACTIVATION;
			cfg_q.limit_conductivity <= mfc_pkg::RST_LIMIT_COND;
			cfg_q.inv_burnup_scale   <= mfc_pkg::RST_INV_BURNUP;
			cfg_q.porosity_factor    <= mfc_pkg::RST_POROSITY;
			cfg_q.perturb_gain       <= mfc_pkg::RST_PERTURB;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mfc_pkg::CFG_DENOM_OFFSET: cfg_q.denom_offset       <= cfg_data;
				mfc_pkg::CFG_DENOM_SLOPE:  cfg_q.denom_slope        <= cfg_data;
				mfc_pkg::CFG_PHONON_COEF:  cfg_q.phonon_coef        <= cfg_data[23:0];
				mfc_pkg::CFG_ACTIVATION:   cfg_q.activation_temp    <= cfg_data[19:0];
				mfc_pkg::CFG_LIMIT_COND:   cfg_q.limit_conductivity <= cfg_data[23:0];
				mfc_pkg::CFG_INV_BURNUP:   cfg_q.inv_burnup_scale   <= cfg_data;
				mfc_pkg::CFG_POROSITY:     cfg_q.porosity_factor    <= cfg_data[16:0];
				mfc_pkg::CFG_PERTURB:      cfg_q.perturb_gain       <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// Global advance: the whole pipeline moves when the output register
	// is free or is being read.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Front end: temperature clamp, denominator, exponent numerators.
	logic                      f_v;
	logic [mfc_pkg::DEN_W-1:0] f_den;
	mfc_pkg::front_side_t      f_side;

	mfc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.cfg      (cfg_q),
		.in_v     (in_valid),
		.in_tag   (cell_index),
		.in_temp  (temperature),
		.in_bu    (burnup),
		.out_v    (f_v),
		.out_den  (f_den),
		.out_side (f_side)
	);

	// Electronic term: 2^60 / den, quotient bits 40 down to 0. The top of
	// the numerator is the initial remainder; when it is not below the
	// divisor the quotient overflows and the cap applies.
	logic                       d1_v;
	logic [mfc_pkg::TERM_W-1:0] d1_q;
	mfc_pkg::front_side_t       d1_side;

	mfc_div #(
		.DW (mfc_pkg::DEN_W),
		.QW (mfc_pkg::TERM_W),
		.SW ($bits(mfc_pkg::front_side_t))
	) u_div_term1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (f_v),
		.in_rem   (mfc_pkg::DIV1_REM),
		.in_div   (f_den),
		.in_num   ({mfc_pkg::TERM_W{1'b0}}),
		.in_side  (f_side),
		.out_v    (d1_v),
		.out_quo  (d1_q),
		.out_side (d1_side)
	);

	// Capped electronic term travels on; the next divider forms E*log2e/T
	// from bit 14 upward, which is all the exponent needs.
	mfc_pkg::d2_side_t d2_in;
	assign d2_in.tag   = d1_side.tag;
	assign d2_in.term1 = (d1_side.ovf || (d1_q > mfc_pkg::TERM_CAP)) ? mfc_pkg::TERM_CAP : d1_q;
	assign d2_in.tsq   = d1_side.tsq;
	assign d2_in.yb    = d1_side.yb;

	logic                     d2_v;
	logic [mfc_pkg::YE_W-1:0] d2_q;
	mfc_pkg::d2_side_t        d2_side;

	mfc_div #(
		.DW (mfc_pkg::TEMP_W),
		.QW (mfc_pkg::YE_W),
		.SW ($bits(mfc_pkg::d2_side_t))
	) u_div_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (d1_v),
		.in_rem   ({mfc_pkg::TEMP_W{1'b0}}),
		.in_div   (d1_side.t),
		.in_num   (d1_side.ye),
		.in_side  (d2_in),
		.out_v    (d2_v),
		.out_quo  (d2_q),
		.out_side (d2_side)
	);

	// Both exponentials as 2^-y: the integer part becomes a shift later,
	// the 16-bit fraction goes through the factor chain.
	mfc_pkg::pw_side_t pw_in;
	assign pw_in.tag   = d2_side.tag;
	assign pw_in.term1 = d2_side.term1;
	assign pw_in.tsq   = d2_side.tsq;
	assign pw_in.ne    = d2_q[mfc_pkg::YE_W-1:mfc_pkg::FRAC_W];
	assign pw_in.nb    = d2_side.yb[mfc_pkg::YB_W-1:30];

	logic                      pw_v;
	logic [mfc_pkg::ACC_W-1:0] pw_pa;
	logic [mfc_pkg::ACC_W-1:0] pw_pb;
	mfc_pkg::pw_side_t         pw_side;

	mfc_pow2 #(
		.SW ($bits(mfc_pkg::pw_side_t))
	) u_pow2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (d2_v),
		.in_fa    (d2_q[mfc_pkg::FRAC_W-1:0]),
		.in_fb    (d2_side.yb[29:14]),
		.in_side  (pw_in),
		.out_v    (pw_v),
		.out_pa   (pw_pa),
		.out_pb   (pw_pb),
		.out_side (pw_side)
	);

	// Phonon numerator D*p shifted by the exponent, burnup decay factor.
	logic                       m_v;
	logic [mfc_pkg::TSQ_W-1:0]  m_rem;
	logic [mfc_pkg::TERM_W-1:0] m_num;
	logic [mfc_pkg::TSQ_W-1:0]  m_div;
	mfc_pkg::d3_side_t          m_side;

	mfc_mid u_mid (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.cfg      (cfg_q),
		.in_v     (pw_v),
		.in_pa    (pw_pa),
		.in_pb    (pw_pb),
		.in_side  (pw_side),
		.out_v    (m_v),
		.out_rem  (m_rem),
		.out_num  (m_num),
		.out_div  (m_div),
		.out_side (m_side)
	);

	// Phonon term: numerator / T^2, same overflow scheme as the first term.
	logic                       d3_v;
	logic [mfc_pkg::TERM_W-1:0] d3_q;
	mfc_pkg::d3_side_t          d3_side;

	mfc_div #(
		.DW (mfc_pkg::TSQ_W),
		.QW (mfc_pkg::TERM_W),
		.SW ($bits(mfc_pkg::d3_side_t))
	) u_div_term2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (m_v),
		.in_rem   (m_rem),
		.in_div   (m_div),
		.in_num   (m_num),
		.in_side  (m_side),
		.out_v    (d3_v),
		.out_quo  (d3_q),
		.out_side (d3_side)
	);

	// Back end: sum, porosity, blend toward the asymptote, gain, saturate.
	mfc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.cfg      (cfg_q),
		.in_v     (d3_v),
		.in_q     (d3_q),
		.in_side  (d3_side),
		.out_v    (out_valid),
		.out_tag  (cell_tag),
		.out_cond (conductivity)
	);

	// Beats in flight, for checking only.
	logic [OCC_W-1:0] occ_q;
	logic             acc_in, acc_out;
	assign acc_in  = in_valid && in_ready;
	assign acc_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (acc_in && !acc_out) begin
			occ_q <= occ_q + OCC_W'(1);
		end else if (acc_out && !acc_in) begin
			occ_q <= occ_q - OCC_W'(1);
		end
	end

	`MFC_ASSERT(a_occ_bound, occ_q <= OCC_W'(mfc_pkg::LATENCY), "more beats in flight than stages")
	`MFC_ASSERT_IMPLY(a_out_has_beat, out_valid, occ_q != '0, "result shown with no beat in flight")

endmodule

`default_nettype wire

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// MOX fuel conductivity core testbench
// Streams cell beats through the pipeline under several register settings,
// predicts each conductivity in fixed point and checks results in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import mfc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [63:0] LOG2E = 64'd1549082005;
	localparam logic [63:0] CAP = 64'd1099511627776;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [TEMP_W-1:0] temp;
		logic [BU_W-1:0]   bu;
	} cell_beat_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [COND_W-1:0] cond;
	} cond_beat_t;

	// Factors 2^(-2^-j), j = 1..16, in Q2.30.
	localparam logic [63:0] HALVING_FACTORS [16] = '{
		64'd759250125, 64'd902905651, 64'd984625594, 64'd1028218693,
		64'd1050733751, 64'd1062175491, 64'd1067942999, 64'd1070838486,
		64'd1072289173, 64'd1073015252, 64'd1073378477, 64'd1073560135,
		64'd1073650976, 64'd1073696399, 64'd1073719111, 64'd1073730468
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [TAG_W-1:0] cell_index = '0;
	logic [TEMP_W-1:0] temperature = '0;
	logic [BU_W-1:0] burnup = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [TAG_W-1:0] cell_tag;
	logic [COND_W-1:0] conductivity;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	cfg_t regs_model;
	cell_beat_t cells_pending[$];
	cond_beat_t cond_expected[$];
	int errors = 0;
	int cells_sent = 0;
	int conds_checked = 0;
	int settings_run = 0;
	int burst_left = 0;
	int gap_left = 0;
	int idle_cycles = 0;
	longint cycle_count = 0;

	mox_fuel_conductivity_eval_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cell_index(cell_index), .temperature(temperature), .burnup(burnup),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell_tag(cell_tag), .conductivity(conductivity),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// 2^-(f/65536) in Q2.30, one rounded product per set fraction bit.
	function automatic logic [63:0] pow2_fraction(input logic [15:0] f);
		logic [63:0] acc;
		acc = 64'd1 << 30;
		for (int i = 0; i < 16; i++) begin
			if (f[15-i])
				acc = (acc * HALVING_FACTORS[i] + (64'd1 << 29)) >> 30;
		end
		return acc;
	endfunction

	// Conductivity of one cell under the current register model. All
	// arithmetic is 64-bit and wraps the way the datapath definition does.
	function automatic logic [COND_W-1:0] conductivity_of(input logic [TEMP_W-1:0] temp_in,
			input logic [BU_W-1:0] bu_in);
		logic [63:0] t, den, term1, term2, y, n, p, num, k0, z, eb, kinf, nom, res;
		t = (temp_in == 0) ? 64'd1 : 64'(temp_in);
		den = (64'(regs_model.denom_offset) << 12) + 64'(regs_model.denom_slope) * t;
		term1 = (den == 0) ? CAP : ((64'd1 << 60) / den);
		if (term1 > CAP)
			term1 = CAP;
		y = (64'(regs_model.activation_temp) * LOG2E) / t;
		n = y >> 30;
		p = pow2_fraction(y[29:14]);
		num = 64'(regs_model.phonon_coef) * p;
		if (n <= 10)
			num = num << (10 - n);
		else if (n - 10 >= 64)
			num = 0;
		else
			num = num >> (n - 10);
		term2 = num / (t * t);
		if (term2 > CAP)
			term2 = CAP;
		k0 = ((term1 + term2) * 64'(regs_model.porosity_factor)) >> 16;
		z = (64'(bu_in) * 64'(regs_model.inv_burnup_scale)) >> 20;
		y = (z * LOG2E) >> 20;
		n = y >> 30;
		p = pow2_fraction(y[29:14]);
		eb = (n + 8 >= 64) ? 64'd0 : (p >> (n + 8));
		kinf = 64'(regs_model.limit_conductivity);
		if (k0 >= kinf)
			nom = kinf + (((k0 - kinf) * eb) >> 22);
		else
			nom = kinf - (((kinf - k0) * eb) >> 22);
		res = (nom * 64'(regs_model.perturb_gain)) >> 16;
		if (res > 64'(OUT_MAX))
			res = 64'(OUT_MAX);
		return res[COND_W-1:0];
	endfunction

	// Driver: presents pending cells in bursts with random gaps. A beat that is
	// not taken stays on the bus untouched.
	always @(posedge clk or negedge arst_n) begin
		logic fire;
		logic next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			fire = in_valid && in_ready;
			next_valid = 1'b0;
			if (fire) begin
				cond_expected.push_back('{tag: cell_index,
					cond: conductivity_of(temperature, burnup)});
				void'(cells_pending.pop_front());
				cells_sent++;
			end
			if (in_valid && !fire) begin
				next_valid = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (cells_pending.size() > 0) begin
				next_valid = 1'b1;
				cell_index <= cells_pending[0].tag;
				temperature <= cells_pending[0].temp;
				burnup <= cells_pending[0].bu;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					// A third of the bursts run back to back with the next one.
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			in_valid <= next_valid;
		end
	end

	// Monitor: checks each accepted result against the oldest prediction and
	// drives out_ready from four stall patterns that are used in turn.
	always @(posedge clk or negedge arst_n) begin
		cond_beat_t want;
		logic next_ready;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			cycle_count++;
			if (out_valid && out_ready) begin
				if (cond_expected.size() == 0) begin
					$error("unexpected result beat: tag %0h conductivity %0h",
						cell_tag, conductivity);
					errors++;
				end else begin
					want = cond_expected.pop_front();
					if (cell_tag !== want.tag) begin
						$error("cell_tag: expected %0h, got %0h", want.tag, cell_tag);
						errors++;
					end
					if (conductivity !== want.cond) begin
						$error("conductivity: expected %0h, got %0h", want.cond,
							conductivity);
						errors++;
					end
					conds_checked++;
				end
			end
			case ((cycle_count >> 7) % 4)
				0: next_ready = 1'b1;
				1: next_ready = $urandom_range(0, 1);
				2: next_ready = ($urandom_range(0, 3) == 0);
				default: next_ready = ((cycle_count % 40) < 12);
			endcase
			out_ready <= next_ready;
		end
	end

	// Watchdog: counts cycles with work outstanding but no beat moving.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cells_pending.size() == 0 && cond_expected.size() == 0 && !in_valid)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL mox_fuel_conductivity_eval_core");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// One register write, mirrored into the model with the register's width.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_DENOM_OFFSET: regs_model.denom_offset = val;
			CFG_DENOM_SLOPE:  regs_model.denom_slope = val;
			CFG_PHONON_COEF:  regs_model.phonon_coef = val[23:0];
			CFG_ACTIVATION:   regs_model.activation_temp = val[19:0];
			CFG_LIMIT_COND:   regs_model.limit_conductivity = val[23:0];
			CFG_INV_BURNUP:   regs_model.inv_burnup_scale = val;
			CFG_POROSITY:     regs_model.porosity_factor = val[16:0];
			default:          regs_model.perturb_gain = val[19:0];
		endcase
	endtask

	task automatic write_all(input logic [31:0] a, input logic [31:0] b, input logic [31:0] d,
			input logic [31:0] e, input logic [31:0] kinf, input logic [31:0] inv,
			input logic [31:0] pf, input logic [31:0] gain);
		write_reg(CFG_DENOM_OFFSET, a);
		write_reg(CFG_DENOM_SLOPE, b);
		write_reg(CFG_PHONON_COEF, d);
		write_reg(CFG_ACTIVATION, e);
		write_reg(CFG_LIMIT_COND, kinf);
		write_reg(CFG_INV_BURNUP, inv);
		write_reg(CFG_POROSITY, pf);
		write_reg(CFG_PERTURB, gain);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// Waits until every queued cell has been sent and every result checked.
	task automatic wait_drained();
		while (cells_pending.size() > 0 || in_valid || cond_expected.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_cell(input logic [TAG_W-1:0] tag, input logic [TEMP_W-1:0] temp,
			input logic [BU_W-1:0] bu);
		cells_pending.push_back('{tag: tag, temp: temp, bu: bu});
	endtask

	// Random cell: half reactor-like temperatures, the rest full-range values, low
	// values and extremes.
	task automatic queue_random_cells(input int count);
		logic [TEMP_W-1:0] temp;
		logic [BU_W-1:0] bu;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 7))
				0: temp = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
				1, 2: temp = $urandom;
				3: temp = $urandom_range(1, 64);
				default: temp = $urandom_range(4000, 48000);
			endcase
			case ($urandom_range(0, 3))
				0: bu = $urandom_range(0, 2000);
				1: bu = $urandom_range(0, 60000);
				default: bu = $urandom;
			endcase
			queue_cell($urandom, temp, bu);
		end
	endtask

	initial begin
		regs_model = '{RST_DENOM_OFFSET, RST_DENOM_SLOPE, RST_PHONON_COEF, RST_ACTIVATION,
			RST_LIMIT_COND, RST_INV_BURNUP, RST_POROSITY, RST_PERTURB};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cells under the reset settings: field extremes, zero
		// temperatures, and realistic points along the burnup curve.
		queue_cell(24'h000000, 16'd0, 18'd0);
		queue_cell(24'hFFFFFF, 16'd1, 18'd0);
		queue_cell(24'h5A5A5A, 16'hFFFF, 18'h3FFFF);
		queue_cell(24'hA5A5A5, 16'd0, 18'h3FFFF);
		queue_cell(24'h000001, 16'hFFFF, 18'd0);
		queue_cell(24'h123456, 16'd4800, 18'd0);
		queue_cell(24'h234567, 16'd16000, 18'd10000);
		queue_cell(24'h345678, 16'd24000, 18'd40000);
		queue_cell(24'h456789, 16'd32000, 18'd100000);
		queue_cell(24'h56789A, 16'd48000, 18'd262143);
		queue_cell(24'h6789AB, 16'd2, 18'd1);
		queue_cell(24'h789ABC, 16'h8000, 18'h20000);
		wait_drained();

		// Zero denominator, huge activation temperature, porosity factor above
		// one and the largest gain: term1 at its cap and the output saturating.
		write_all(32'd0, 32'd0, 32'hFFFFFF, 32'hFFFFF, 32'hFFFFFF, 32'd0, 32'h1FFFF, 32'hFFFFF);
		queue_cell(24'h000010, 16'd0, 18'd0);
		queue_cell(24'h000011, 16'hFFFF, 18'h3FFFF);
		queue_cell(24'h000012, 16'd1, 18'd12345);
		queue_cell(24'h000013, 16'd30000, 18'd0);
		wait_drained();

		// Every register at its all-ones value, then all at zero.
		write_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFF, 32'hFFFFF, 32'hFFFFFF,
			32'hFFFFFFFF, 32'h1FFFF, 32'hFFFFF);
		queue_cell(24'h000020, 16'd0, 18'd0);
		queue_cell(24'h000021, 16'hFFFF, 18'h3FFFF);
		queue_cell(24'h000022, 16'd100, 18'd1);
		queue_random_cells(40);
		wait_drained();
		write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		queue_cell(24'h000030, 16'd5000, 18'd5000);
		queue_random_cells(20);
		wait_drained();

		// Random settings: half stay close to the physical defaults so the
		// exponentials land mid-range, the rest use any register value.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph % 2 == 0)
				write_all(RST_DENOM_OFFSET + $urandom_range(0, 40000000),
					RST_DENOM_SLOPE + $urandom_range(0, 100000000),
					$urandom_range(0, 200000), $urandom_range(150000, 400000),
					$urandom_range(60000, 200000), $urandom_range(0, 40000000),
					$urandom_range(30000, 65536), $urandom_range(40000, 120000));
			else
				write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 131071), $urandom);
			queue_random_cells(120);
			wait_drained();
		end

		// Latency has passed with nothing left outstanding; any stray beat
		// would be flagged by the monitor during this wait.
		repeat (LATENCY + 20) @(posedge clk);
		$display("Checked %0d conductivity results from %0d cells over %0d register settings.",
			conds_checked, cells_sent, settings_run + 1);
		$display("Covered zero and full-scale temperatures, burnup extremes and saturation.");
		if (errors == 0 && cond_expected.size() == 0) begin
			$display("PASS mox_fuel_conductivity_eval_core");
		end else begin
			$display("FAIL mox_fuel_conductivity_eval_core");
		end
		$finish;
	end

endmodule

// File: mox_fuel_conductivity_eval_core.f
+incdir+rtl
rtl/mfc_pkg.sv
rtl/mfc_div.sv
rtl/mfc_pow2.sv
rtl/mfc_front.sv
rtl/mfc_mid.sv
rtl/mfc_back.sv
rtl/mox_fuel_conductivity_eval_core.sv
tb/tb.sv
